// ===== rtl/ema_mean_reversion_quoter_defines.svh =====
// Assertion macros shared by the quoter RTL.
`ifndef EMA_MEAN_REVERSION_QUOTER_DEFINES_SVH
`define EMA_MEAN_REVERSION_QUOTER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EMQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define EMQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/emq_pkg.sv =====
// Package with the constants and types shared by the quoter modules.
package emq_pkg;

   localparam int PRICE_FIELD_BITS = 32;
   localparam int POS_BITS         = 16;
   localparam int WEIGHT_BITS      = 16;
   localparam int FRACTION_BITS    = 24;
   localparam int QTY_BITS         = 16;
   localparam int CAP_BITS         = 15;
   localparam int ORDER_NUM_BITS   = 32;
   localparam int OPB_BITS         = 32;
   localparam int INV_FRAC_BITS    = 16;
   localparam int SKEW_BITS        = 61;
   localparam int CMP_BITS         = SKEW_BITS + 3;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 24;

   localparam logic [SKEW_BITS-1:0] SKEW_LIMIT = {1'b1, {(SKEW_BITS-1){1'b0}}};

   localparam logic [CSR_INDEX_BITS-1:0] REG_EMA_WEIGHT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENTRY_FRACTION = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SKEW_FRACTION  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ORDER_QUANTITY = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_POSITION_CAP   = 3'd4;

   localparam logic [WEIGHT_BITS-1:0]   EMA_WEIGHT_RESET     = 16'd3277;
   localparam logic [FRACTION_BITS-1:0] ENTRY_FRACTION_RESET = 24'd16777;
   localparam logic [FRACTION_BITS-1:0] SKEW_FRACTION_RESET  = 24'd16777;
   localparam logic [QTY_BITS-1:0]      ORDER_QUANTITY_RESET = 16'd100;
   localparam logic [CAP_BITS-1:0]      POSITION_CAP_RESET   = 15'd500;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   typedef struct packed {
      logic start;
      logic frac_shift;
   } mul_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_sts_type;

endpackage

// ===== rtl/emq_if.sv =====
// Handshake interfaces for the quote, order and register channels.
interface emq_req_if;
   import emq_pkg::*;
   logic                        valid;
   logic                        ready;
   logic [PRICE_FIELD_BITS-1:0] bid_price;
   logic [PRICE_FIELD_BITS-1:0] ask_price;
   logic signed [POS_BITS-1:0]  held_position;
   modport source (output valid, bid_price, ask_price, held_position, input ready);
   modport sink (input valid, bid_price, ask_price, held_position, output ready);
endinterface

interface emq_rsp_if;
   import emq_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        order_valid;
   logic                        order_side;
   logic [PRICE_FIELD_BITS-1:0] order_price;
   logic [QTY_BITS-1:0]         order_size;
   logic [ORDER_NUM_BITS-1:0]   order_number;
   modport source (output valid, order_valid, order_side, order_price, order_size,
                   order_number, input ready);
   modport sink (input valid, order_valid, order_side, order_price, order_size,
                 order_number, output ready);
endinterface

interface emq_csr_if;
   import emq_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

// ===== rtl/emq_mul.sv =====
// Shared multiply, round and saturate unit working on 32-bit slices of operand A.
module emq_mul #(
   parameter int A_BITS = 48
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  emq_pkg::mul_ctl_type                 ctl,
   input  logic [A_BITS-1:0]                    oper_a,
   input  logic [emq_pkg::OPB_BITS-1:0]         oper_b,
   output emq_pkg::mul_sts_type                 sts,
   output logic [emq_pkg::SKEW_BITS-1:0]        result
);
   import emq_pkg::*;

   localparam int NCH       = (A_BITS + OPB_BITS - 1) / OPB_BITS;
   localparam int PAD_BITS  = NCH * OPB_BITS;
   localparam int ACC_BITS  = PAD_BITS + OPB_BITS;
   localparam int SH_BITS   = $clog2(ACC_BITS);
   localparam int STEP_BITS = $clog2(NCH + 2);
   localparam int PROD_BITS = 2 * OPB_BITS;

   localparam logic [ACC_BITS-1:0] HALF_WEIGHT   = ACC_BITS'(1) << (WEIGHT_BITS - 1);
   localparam logic [ACC_BITS-1:0] HALF_FRACTION = ACC_BITS'(1) << (FRACTION_BITS - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [PAD_BITS-1:0]  opa_ff, opa_in;
   logic [OPB_BITS-1:0]  opb_ff, opb_in;
   logic                 frac_ff, frac_in;
   logic [PROD_BITS-1:0] prod_ff, prod_in;
   logic [ACC_BITS-1:0]  acc_ff, acc_in;
   logic [SH_BITS-1:0]   shamt_ff, shamt_in;
   logic [SKEW_BITS-1:0] res_ff, res_in;
   logic [ACC_BITS-1:0]  shifted;
   logic                 saturate;

   assign shifted  = frac_ff ? (acc_ff >> FRACTION_BITS) : (acc_ff >> WEIGHT_BITS);
   assign saturate = shifted > ACC_BITS'(SKEW_LIMIT);

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      frac_in  = frac_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      shamt_in = shamt_ff;
      res_in   = res_ff;
      if (ctl.start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         opa_in   = PAD_BITS'(oper_a);
         opb_in   = oper_b;
         frac_in  = ctl.frac_shift;
         acc_in   = ctl.frac_shift ? HALF_FRACTION : HALF_WEIGHT;
         shamt_in = '0;
      end else if (busy_ff) begin
         step_in = step_ff + STEP_BITS'(1);
         if (step_ff < STEP_BITS'(NCH)) begin
            prod_in = PROD_BITS'(opa_ff[OPB_BITS-1:0]) * PROD_BITS'(opb_ff);
            opa_in  = opa_ff >> OPB_BITS;
         end
         if (step_ff >= STEP_BITS'(1) && step_ff <= STEP_BITS'(NCH)) begin
            acc_in   = acc_ff + (ACC_BITS'(prod_ff) << shamt_ff);
            shamt_in = shamt_ff + SH_BITS'(OPB_BITS);
         end
         if (step_ff == STEP_BITS'(NCH + 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = saturate ? SKEW_LIMIT : shifted[SKEW_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      frac_ff  <= frac_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      shamt_ff <= shamt_in;
      res_ff   <= res_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = res_ff;

endmodule

// ===== rtl/emq_div.sv =====
// Restoring divider for the rounded position-to-cap ratio, one quotient bit per cycle.
module emq_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [emq_pkg::POS_BITS-1:0]     pos_mag,
   input  logic [emq_pkg::CAP_BITS-1:0]     divisor,
   output logic                             busy,
   output logic [emq_pkg::OPB_BITS-1:0]     quotient
);
   import emq_pkg::*;

   localparam int CNT_BITS = $clog2(OPB_BITS);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [OPB_BITS-1:0] num_ff, num_in;
   logic [CAP_BITS-1:0] rem_ff, rem_in;
   logic [CAP_BITS-1:0] div_ff, div_in;
   logic [CAP_BITS:0]   rem_sh;
   logic [CAP_BITS:0]   rem_sub;
   logic                fits;

   assign rem_sh  = {rem_ff, num_ff[OPB_BITS-1]};
   assign rem_sub = rem_sh - {1'b0, div_ff};
   assign fits    = rem_sh >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = {pos_mag, {INV_FRAC_BITS{1'b0}}} + OPB_BITS'(divisor >> 1);
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_BITS'(1);
         num_in = {num_ff[OPB_BITS-2:0], fits};
         rem_in = fits ? rem_sub[CAP_BITS-1:0] : rem_sh[CAP_BITS-1:0];
         if (cnt_ff == CNT_BITS'(OPB_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = (div_ff == '0) ? '0 : num_ff;

endmodule

// ===== rtl/ema_mean_reversion_quoter.sv =====
// Top level of the EMA mean-reversion quoter with inventory skew.
//
//  channel   direction  transaction
//  -------   ---------  ------------------------------------------------
//  req_chan  in         one top-of-book update: bid, ask, held position
//  rsp_chan  out        one result per update, order fields or all zero
//  csr_chan  in         one register write: index and data
//
// A two-sided update after seeding has its result once the 32-step divider for the
// position ratio has finished, which outlasts the multiplies that run beside it, and
// one more pass of the shared multiplier follows it. One-sided and seeding updates go
// from the prep state straight to the output state.
// Reset restores the register defaults, clears the mean, the seeded flag and the
// order counter. A stalled result holds in the output register, and the next
// update is taken once the result has been loaded there.
module ema_mean_reversion_quoter #(
   parameter int PRICE_BITS     = 32,
   parameter int MEAN_FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   emq_req_if.sink    req_chan,
   emq_rsp_if.source  rsp_chan,
   emq_csr_if.sink    csr_chan
);
   import emq_pkg::*;
   `include "ema_mean_reversion_quoter_defines.svh"

   localparam int IPW    = (PRICE_BITS < PRICE_FIELD_BITS) ? PRICE_BITS : PRICE_FIELD_BITS;
   localparam int MEAN_W = IPW + MEAN_FRAC_BITS;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_PREP     = 4'd1;
   localparam logic [3:0] S_EMA      = 4'd2;
   localparam logic [3:0] S_THR_GO   = 4'd3;
   localparam logic [3:0] S_THR_WAIT = 4'd4;
   localparam logic [3:0] S_FSK_GO   = 4'd5;
   localparam logic [3:0] S_FSK_WAIT = 4'd6;
   localparam logic [3:0] S_SKW_GO   = 4'd7;
   localparam logic [3:0] S_SKW_WAIT = 4'd8;
   localparam logic [3:0] S_RES      = 4'd9;
   localparam logic [3:0] S_DEC      = 4'd10;
   localparam logic [3:0] S_OUT      = 4'd11;

   logic [3:0]                state_ff, state_in;
   logic [WEIGHT_BITS-1:0]    weight_ff, weight_in;
   logic [FRACTION_BITS-1:0]  entry_ff, entry_in;
   logic [FRACTION_BITS-1:0]  skewf_ff, skewf_in;
   logic [QTY_BITS-1:0]       qty_ff, qty_in;
   logic [CAP_BITS-1:0]       cap_ff, cap_in;
   logic [MEAN_W-1:0]         mean_ff, mean_in;
   logic                      seeded_ff, seeded_in;
   logic [ORDER_NUM_BITS-1:0] next_num_ff, next_num_in;
   logic [IPW-1:0]            bid_ff, bid_in;
   logic [IPW-1:0]            ask_ff, ask_in;
   logic [POS_BITS-1:0]       pos_ff, pos_in;
   logic                      up_ff, up_in;
   logic [MEAN_W-1:0]         thr_ff, thr_in;
   logic [MEAN_W-1:0]         fsk_ff, fsk_in;
   logic [SKEW_BITS-1:0]      skw_ff, skw_in;
   logic signed [CMP_BITS-1:0] res_ff, res_in;
   logic                      order_ff, order_in;
   logic                      side_ff, side_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_order_ff, rsp_order_in;
   logic                      rsp_side_ff, rsp_side_in;
   logic [PRICE_FIELD_BITS-1:0] rsp_price_ff, rsp_price_in;
   logic [QTY_BITS-1:0]       rsp_size_ff, rsp_size_in;
   logic [ORDER_NUM_BITS-1:0] rsp_num_ff, rsp_num_in;

   logic                      req_accept;
   logic                      csr_accept;
   logic [MEAN_W-1:0]         mid_w;
   logic                      mid_up;
   logic [MEAN_W-1:0]         diff_w;
   logic [MEAN_W-1:0]         delta_w;
   logic [POS_BITS-1:0]       pos_mag;
   logic signed [CMP_BITS-1:0] mean_s;
   logic signed [CMP_BITS-1:0] skew_s;
   logic signed [CMP_BITS-1:0] thr_s;
   logic signed [CMP_BITS-1:0] ask_q;
   logic signed [CMP_BITS-1:0] bid_q;
   logic signed [POS_BITS:0]  pos_x;
   logic signed [POS_BITS:0]  cap_x;
   logic                      buy_ok;
   logic                      sell_ok;

   mul_ctl_type               mul_ctl;
   mul_sts_type               mul_sts;
   logic [MEAN_W-1:0]         mul_a;
   logic [OPB_BITS-1:0]       mul_b;
   logic [SKEW_BITS-1:0]      mul_res;
   logic                      div_start;
   logic                      div_busy;
   logic [OPB_BITS-1:0]       div_quot;

   emq_mul #(.A_BITS(MEAN_W)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mul_ctl),
      .oper_a (mul_a),
      .oper_b (mul_b),
      .sts    (mul_sts),
      .result (mul_res)
   );

   emq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .pos_mag  (pos_mag),
      .divisor  (cap_ff),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   assign req_accept = req_chan.valid && req_chan.ready;
   assign csr_accept = csr_chan.valid && csr_chan.ready;

   assign mid_w   = {MEAN_W'(IPW'(bid_ff) + IPW'(0)) + MEAN_W'(ask_ff) + MEAN_W'(0)}
                    << (MEAN_FRAC_BITS - 1);
   assign mid_up  = mid_w >= mean_ff;
   assign diff_w  = mid_up ? (mid_w - mean_ff) : (mean_ff - mid_w);
   assign delta_w = mul_res[MEAN_W-1:0];
   assign pos_mag = pos_ff[POS_BITS-1] ? (~pos_ff + POS_BITS'(1)) : pos_ff;

   assign mean_s = signed'(CMP_BITS'(mean_ff));
   assign skew_s = pos_ff[POS_BITS-1] ? -signed'(CMP_BITS'(skw_ff))
                                      : signed'(CMP_BITS'(skw_ff));
   assign thr_s  = signed'(CMP_BITS'(thr_ff));
   assign ask_q  = signed'(CMP_BITS'({ask_ff, {MEAN_FRAC_BITS{1'b0}}}));
   assign bid_q  = signed'(CMP_BITS'({bid_ff, {MEAN_FRAC_BITS{1'b0}}}));
   assign pos_x  = signed'({pos_ff[POS_BITS-1], pos_ff});
   assign cap_x  = signed'({2'b00, cap_ff});
   assign buy_ok  = (ask_q < res_ff - thr_s) && (pos_x < cap_x);
   assign sell_ok = (bid_q > res_ff + thr_s) && (pos_x > -cap_x);

   always_comb begin
      state_in     = state_ff;
      weight_in    = weight_ff;
      entry_in     = entry_ff;
      skewf_in     = skewf_ff;
      qty_in       = qty_ff;
      cap_in       = cap_ff;
      mean_in      = mean_ff;
      seeded_in    = seeded_ff;
      next_num_in  = next_num_ff;
      bid_in       = bid_ff;
      ask_in       = ask_ff;
      pos_in       = pos_ff;
      up_in        = up_ff;
      thr_in       = thr_ff;
      fsk_in       = fsk_ff;
      skw_in       = skw_ff;
      res_in       = res_ff;
      order_in     = order_ff;
      side_in      = side_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_order_in = rsp_order_ff;
      rsp_side_in  = rsp_side_ff;
      rsp_price_in = rsp_price_ff;
      rsp_size_in  = rsp_size_ff;
      rsp_num_in   = rsp_num_ff;
      mul_ctl      = '0;
      mul_a        = mean_ff;
      mul_b        = OPB_BITS'(weight_ff);
      div_start    = 1'b0;

      if (csr_accept) begin
         unique case (csr_chan.index)
            REG_EMA_WEIGHT:     weight_in = csr_chan.wdata[WEIGHT_BITS-1:0];
            REG_ENTRY_FRACTION: entry_in  = csr_chan.wdata[FRACTION_BITS-1:0];
            REG_SKEW_FRACTION:  skewf_in  = csr_chan.wdata[FRACTION_BITS-1:0];
            REG_ORDER_QUANTITY: qty_in    = csr_chan.wdata[QTY_BITS-1:0];
            REG_POSITION_CAP:   cap_in    = csr_chan.wdata[CAP_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               bid_in   = req_chan.bid_price[IPW-1:0];
               ask_in   = req_chan.ask_price[IPW-1:0];
               pos_in   = req_chan.held_position;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            order_in = 1'b0;
            side_in  = SIDE_BUY;
            if (bid_ff == '0 || ask_ff == '0) begin
               state_in = S_OUT;
            end else if (!seeded_ff) begin
               mean_in   = mid_w;
               seeded_in = 1'b1;
               state_in  = S_OUT;
            end else begin
               up_in         = mid_up;
               mul_ctl.start = 1'b1;
               mul_a         = diff_w;
               mul_b         = OPB_BITS'(weight_ff);
               div_start     = 1'b1;
               state_in      = S_EMA;
            end
         end
         S_EMA: begin
            if (mul_sts.done) begin
               mean_in  = up_ff ? (mean_ff + delta_w) : (mean_ff - delta_w);
               state_in = S_THR_GO;
            end
         end
         S_THR_GO: begin
            mul_ctl.start      = 1'b1;
            mul_ctl.frac_shift = 1'b1;
            mul_a              = mean_ff;
            mul_b              = OPB_BITS'(entry_ff);
            state_in           = S_THR_WAIT;
         end
         S_THR_WAIT: begin
            if (mul_sts.done) begin
               thr_in   = mul_res[MEAN_W-1:0];
               state_in = S_FSK_GO;
            end
         end
         S_FSK_GO: begin
            mul_ctl.start      = 1'b1;
            mul_ctl.frac_shift = 1'b1;
            mul_a              = mean_ff;
            mul_b              = OPB_BITS'(skewf_ff);
            state_in           = S_FSK_WAIT;
         end
         S_FSK_WAIT: begin
            if (mul_sts.done) begin
               fsk_in   = mul_res[MEAN_W-1:0];
               state_in = S_SKW_GO;
            end
         end
         S_SKW_GO: begin
            if (!div_busy) begin
               mul_ctl.start = 1'b1;
               mul_a         = fsk_ff;
               mul_b         = div_quot;
               state_in      = S_SKW_WAIT;
            end
         end
         S_SKW_WAIT: begin
            if (mul_sts.done) begin
               skw_in   = mul_res;
               state_in = S_RES;
            end
         end
         S_RES: begin
            res_in   = mean_s - skew_s;
            state_in = S_DEC;
         end
         S_DEC: begin
            order_in = buy_ok || sell_ok;
            side_in  = buy_ok ? SIDE_BUY : SIDE_SELL;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_order_in = order_ff;
               rsp_side_in  = order_ff && side_ff;
               rsp_price_in = !order_ff ? '0 :
                              (side_ff == SIDE_SELL) ? PRICE_FIELD_BITS'(bid_ff)
                                                     : PRICE_FIELD_BITS'(ask_ff);
               rsp_size_in  = order_ff ? qty_ff : '0;
               rsp_num_in   = order_ff ? next_num_ff : '0;
               if (order_ff) begin
                  next_num_in = next_num_ff + ORDER_NUM_BITS'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         weight_ff    <= EMA_WEIGHT_RESET;
         entry_ff     <= ENTRY_FRACTION_RESET;
         skewf_ff     <= SKEW_FRACTION_RESET;
         qty_ff       <= ORDER_QUANTITY_RESET;
         cap_ff       <= POSITION_CAP_RESET;
         mean_ff      <= '0;
         seeded_ff    <= 1'b0;
         next_num_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         weight_ff    <= weight_in;
         entry_ff     <= entry_in;
         skewf_ff     <= skewf_in;
         qty_ff       <= qty_in;
         cap_ff       <= cap_in;
         mean_ff      <= mean_in;
         seeded_ff    <= seeded_in;
         next_num_ff  <= next_num_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bid_ff       <= bid_in;
      ask_ff       <= ask_in;
      pos_ff       <= pos_in;
      up_ff        <= up_in;
      thr_ff       <= thr_in;
      fsk_ff       <= fsk_in;
      skw_ff       <= skw_in;
      res_ff       <= res_in;
      order_ff     <= order_in;
      side_ff      <= side_in;
      rsp_order_ff <= rsp_order_in;
      rsp_side_ff  <= rsp_side_in;
      rsp_price_ff <= rsp_price_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_num_ff   <= rsp_num_in;
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign csr_chan.ready        = 1'b1;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.order_valid  = rsp_order_ff;
   assign rsp_chan.order_side   = rsp_side_ff;
   assign rsp_chan.order_price  = rsp_price_ff;
   assign rsp_chan.order_size   = rsp_size_ff;
   assign rsp_chan.order_number = rsp_num_ff;

   // The mean moves toward the mid price and never past it.
   `EMQ_ASSERT_NXT(a_mean_no_overshoot, clock, reset, (state_ff == S_EMA) && mul_sts.done, up_ff ? (mean_ff <= mid_w) : (mean_ff >= mid_w), "mean stepped past the mid price")
   // The shared multiplier is only started when it is free.
   `EMQ_ASSERT_IMP(a_mul_free, clock, reset, mul_ctl.start, !mul_sts.busy, "multiplier started while busy")
   // A result without an order carries all-zero order fields.
   `EMQ_ASSERT_IMP(a_empty_result, clock, reset, rsp_valid_ff && !rsp_order_ff, (rsp_price_ff == '0) && (rsp_num_ff == '0) && (rsp_size_ff == '0) && !rsp_side_ff, "empty result carries order fields")
   // Once seeded, the mean stays seeded until reset.
   `EMQ_ASSERT_NXT(a_seed_sticky, clock, reset, seeded_ff, seeded_ff, "seeded flag dropped")

endmodule
